### hdl/cbt_pkg.sv
// ----------------------------------------------------------------------------
// cbt_pkg
// shared types and constants of the csv byte tokenizer
// ----------------------------------------------------------------------------
package cbt_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int MAX_TOKENS  = 3;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_COMMA = 8'h2c;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;

	typedef enum logic [1:0] {
		KIND_BYTE      = 2'd0,
		KIND_FIELD_END = 2'd1,
		KIND_ROW_END   = 2'd2
	} cbt_kind_t;

	typedef struct packed {
		cbt_kind_t  kind;
		logic [7:0] data;
	} cbt_token_t;

	typedef struct packed {
		logic [1:0]                  count;
		cbt_token_t [MAX_TOKENS-1:0] tok;
	} cbt_burst_t;

endpackage

### hdl/csv_byte_tokenizer.sv
// ----------------------------------------------------------------------------
// csv_byte_tokenizer
// streaming csv tokenizer: text bytes in, content bytes and field/row ends out
// ----------------------------------------------------------------------------
//  channel  signals                      content
//  s        s_tvalid s_tready            s_tdata: text_byte   s_tlast: end_of_input
//  m        m_tvalid m_tready            m_tdata: field_byte  m_tuser: token_kind
//                                        m_tlast: last_of_burst
//
//  one input byte per cycle; each byte gives zero to three tokens
//  the output sends one token per cycle while m_tready is high, so the tokens of a
//  byte with two or three go out one by one; a queue of QUEUE_DEPTH bursts absorbs it
//  s_tready drops only while that queue is full
//  reset clears the quoting state, the queue and the output register
// ----------------------------------------------------------------------------
module csv_byte_tokenizer
	import cbt_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] text_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] field_byte
	output logic [1:0] m_tuser,   // [1:0] token_kind
	output logic       m_tlast
);

	cbt_burst_t push_burst;
	cbt_burst_t head;
	logic       push;
	logic       pop;
	logic       empty;
	logic       full;

	cbt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.queue_full (full),
		.push       (push),
		.burst      (push_burst)
	);

	cbt_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_burst (push_burst),
		.pop        (pop),
		.head       (head),
		.empty      (empty),
		.full       (full)
	);

	cbt_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.empty    (empty),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

### hdl/cbt_front.sv
// ----------------------------------------------------------------------------
// cbt_front
// takes text bytes, tracks quoting and row state, builds token bursts
// ----------------------------------------------------------------------------
module cbt_front
	import cbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	input  logic       queue_full,
	output logic       push,
	output cbt_burst_t burst
);

	typedef struct packed {
		logic inside_quotes;
		logic quote_pending;
		logic carriage_return_pending;
		logic field_begun;
		logic field_has_content;
		logic row_has_ended_fields;
	} state_t;

	typedef struct packed {
		state_t     st;
		logic       emit;
		cbt_token_t tok;
	} step_t;

	state_t     st_q;
	state_t     st_d;
	cbt_burst_t burst_d;
	step_t      ob;
	logic       accept;

	function automatic cbt_burst_t add_tok(cbt_burst_t b, cbt_token_t t);
		cbt_burst_t r;
		r = b;
		case (b.count)
			2'd0:    r.tok[0] = t;
			2'd1:    r.tok[1] = t;
			default: r.tok[2] = t;
		endcase
		r.count = b.count + 2'd1;
		return r;
	endfunction

	function automatic step_t close_row(state_t s);
		step_t r;
		r.st   = s;
		r.emit = s.field_has_content | s.row_has_ended_fields;
		r.tok  = '{kind: KIND_ROW_END, data: 8'd0};
		r.st.field_begun          = 1'b0;
		r.st.field_has_content    = 1'b0;
		r.st.row_has_ended_fields = 1'b0;
		return r;
	endfunction

	function automatic step_t outside_byte(state_t s, logic [7:0] c, logic last);
		step_t r;
		r.st   = s;
		r.emit = 1'b0;
		r.tok  = '{kind: KIND_BYTE, data: 8'd0};
		if (c == CH_QUOTE && !s.field_begun && !s.field_has_content) begin
			r.st.inside_quotes = 1'b1;
			r.st.field_begun   = 1'b1;
		end else if (c == CH_COMMA) begin
			r.emit = 1'b1;
			r.tok  = '{kind: KIND_FIELD_END, data: 8'd0};
			r.st.field_begun          = 1'b0;
			r.st.field_has_content    = 1'b0;
			r.st.row_has_ended_fields = 1'b1;
		end else if (c == CH_CR) begin
			if (last) begin
				r = close_row(s);
			end else begin
				r.st.carriage_return_pending = 1'b1;
			end
		end else if (c == CH_LF) begin
			r = close_row(s);
		end else begin
			r.emit = 1'b1;
			r.tok  = '{kind: KIND_BYTE, data: c};
			r.st.field_begun       = 1'b1;
			r.st.field_has_content = 1'b1;
		end
		return r;
	endfunction

	always_comb begin
		st_d    = st_q;
		burst_d = '0;
		ob      = '0;
		if (st_q.carriage_return_pending) begin
			st_d.carriage_return_pending = 1'b0;
			ob = close_row(st_d);
			st_d = ob.st;
			if (ob.emit) begin
				burst_d = add_tok(burst_d, ob.tok);
			end
			if (in_byte != CH_LF) begin
				ob = outside_byte(st_d, in_byte, in_last);
				st_d = ob.st;
				if (ob.emit) begin
					burst_d = add_tok(burst_d, ob.tok);
				end
			end
		end else if (st_q.quote_pending) begin
			st_d.quote_pending = 1'b0;
			if (in_byte == CH_QUOTE) begin
				burst_d = add_tok(burst_d, '{kind: KIND_BYTE, data: CH_QUOTE});
				st_d.field_has_content = 1'b1;
			end else begin
				st_d.inside_quotes = 1'b0;
				ob = outside_byte(st_d, in_byte, in_last);
				st_d = ob.st;
				if (ob.emit) begin
					burst_d = add_tok(burst_d, ob.tok);
				end
			end
		end else if (st_q.inside_quotes) begin
			if (in_byte == CH_QUOTE) begin
				if (in_last) begin
					st_d.inside_quotes = 1'b0;
				end else begin
					st_d.quote_pending = 1'b1;
				end
			end else begin
				burst_d = add_tok(burst_d, '{kind: KIND_BYTE, data: in_byte});
				st_d.field_has_content = 1'b1;
			end
		end else begin
			ob = outside_byte(st_d, in_byte, in_last);
			st_d = ob.st;
			if (ob.emit) begin
				burst_d = add_tok(burst_d, ob.tok);
			end
		end
		if (in_last) begin
			if (st_d.field_begun || st_d.field_has_content || st_d.row_has_ended_fields) begin
				ob = close_row(st_d);
				if (ob.emit) begin
					burst_d = add_tok(burst_d, ob.tok);
				end
			end
			st_d = '0;
		end
	end

	assign in_ready = ~queue_full;
	assign accept   = in_valid & in_ready;
	assign push     = accept & (burst_d.count != 2'd0);
	assign burst    = burst_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (accept) begin
			st_q <= st_d;
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.quote_pending |-> st_q.inside_quotes)
		else $error("quote pending outside quotes");
	assert property (@(posedge clk) disable iff (!arst_n)
		st_q.carriage_return_pending |-> !st_q.inside_quotes && !st_q.quote_pending)
		else $error("cr pending inside quotes");
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |=> st_q == '0)
		else $error("state not cleared after final byte");
`endif

endmodule

### hdl/cbt_queue.sv
// ----------------------------------------------------------------------------
// cbt_queue
// small fifo of token bursts between front and back
// ----------------------------------------------------------------------------
module cbt_queue
	import cbt_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  cbt_burst_t push_burst,
	input  logic       pop,
	output cbt_burst_t head,
	output logic       empty,
	output logic       full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cbt_burst_t          mem_q [DEPTH];
	logic       [PW-1:0] wr_ptr_q;
	logic       [PW-1:0] rd_ptr_q;
	logic       [CW-1:0] cnt_q;

	assign empty = (cnt_q == '0);
	assign full  = (cnt_q == CW'(DEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_burst;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && full |-> pop) and (pop |-> !empty))
		else $error("queue overflow or underflow");
`endif

endmodule

### hdl/cbt_back.sv
// ----------------------------------------------------------------------------
// cbt_back
// unpacks queued bursts into one token per transfer on the output register
// ----------------------------------------------------------------------------
module cbt_back
	import cbt_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  cbt_burst_t head,
	input  logic       empty,
	output logic       pop,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,
	output logic [1:0] m_tuser,
	output logic       m_tlast
);

	logic [1:0] idx_q;
	cbt_token_t tok;
	cbt_token_t tok_q;
	logic       last_q;
	logic       valid_q;
	logic       load;
	logic       is_last;

	always_comb begin
		case (idx_q)
			2'd0:    tok = head.tok[0];
			2'd1:    tok = head.tok[1];
			default: tok = head.tok[2];
		endcase
	end

	assign is_last = (idx_q == head.count - 2'd1);
	assign load    = !empty && (!valid_q || m_tready);
	assign pop     = load && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tok_q  <= tok;
			last_q <= is_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = tok_q.data;
	assign m_tuser  = tok_q.kind;
	assign m_tlast  = last_q;

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> !empty && idx_q < head.count)
		else $error("burst index past queued burst");
`endif

endmodule

### tb/csv_byte_tokenizer_test.sv
// ----------------------------------------------------------------------------
// csv_byte_tokenizer_test
// self-checking bench for the csv byte tokenizer: directed text covering the
// quoting rules, row endings, blank rows and final-byte flushes, then random
// csv-like text with noise; every output token is compared against a
// behavioral tokenizer kept in step with the accepted input bytes
// ----------------------------------------------------------------------------
module csv_byte_tokenizer_test;
	import cbt_pkg::*;

	typedef struct packed {
		cbt_kind_t  kind;
		logic [7:0] data;
		logic       last;
	} token_exp_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b1;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic [1:0] m_tuser;
	logic       m_tlast;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int bytes_sent = 0;
	int mismatch_count = 0;

	token_exp_t expected_tokens[$];
	token_exp_t want;

	// tokenizer state
	bit in_quotes;
	bit quote_seen;
	bit cr_seen;
	bit field_open;
	bit field_filled;
	bit row_has_fields;

	cbt_kind_t  burst_kind[MAX_TOKENS];
	logic [7:0] burst_data[MAX_TOKENS];
	int         burst_len;

	csv_byte_tokenizer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void add_token(cbt_kind_t k, logic [7:0] d);
		if (burst_len < MAX_TOKENS) begin
			burst_kind[burst_len] = k;
			burst_data[burst_len] = d;
			burst_len++;
		end
	endfunction

	function automatic void close_row();
		if (field_filled || row_has_fields)
			add_token(KIND_ROW_END, 8'h00);
		field_open     = 1'b0;
		field_filled   = 1'b0;
		row_has_fields = 1'b0;
	endfunction

	function automatic void unquoted_byte(logic [7:0] b, logic eoi);
		if (b == CH_QUOTE && !field_open && !field_filled) begin
			in_quotes  = 1'b1;
			field_open = 1'b1;
		end else if (b == CH_COMMA) begin
			add_token(KIND_FIELD_END, 8'h00);
			field_open     = 1'b0;
			field_filled   = 1'b0;
			row_has_fields = 1'b1;
		end else if (b == CH_CR) begin
			if (eoi)
				close_row();
			else
				cr_seen = 1'b1;
		end else if (b == CH_LF) begin
			close_row();
		end else begin
			add_token(KIND_BYTE, b);
			field_open   = 1'b1;
			field_filled = 1'b1;
		end
	endfunction

	function automatic void tokenize_byte(logic [7:0] b, logic eoi);
		token_exp_t t;
		burst_len = 0;
		if (cr_seen) begin
			cr_seen = 1'b0;
			close_row();
			if (b != CH_LF)
				unquoted_byte(b, eoi);
		end else if (quote_seen) begin
			quote_seen = 1'b0;
			if (b == CH_QUOTE) begin
				add_token(KIND_BYTE, CH_QUOTE);
				field_filled = 1'b1;
			end else begin
				in_quotes = 1'b0;
				unquoted_byte(b, eoi);
			end
		end else if (in_quotes) begin
			if (b == CH_QUOTE) begin
				if (eoi)
					in_quotes = 1'b0;
				else
					quote_seen = 1'b1;
			end else begin
				add_token(KIND_BYTE, b);
				field_filled = 1'b1;
			end
		end else begin
			unquoted_byte(b, eoi);
		end
		if (eoi) begin
			if (field_open || field_filled || row_has_fields)
				close_row();
			in_quotes      = 1'b0;
			quote_seen     = 1'b0;
			cr_seen        = 1'b0;
			field_open     = 1'b0;
			field_filled   = 1'b0;
			row_has_fields = 1'b0;
		end
		for (int i = 0; i < burst_len; i++) begin
			t.kind = burst_kind[i];
			t.data = burst_data[i];
			t.last = (i == burst_len - 1);
			expected_tokens.insert(expected_tokens.size(), t);
		end
	endfunction

	task automatic send_text_byte(input logic [7:0] b, input logic eoi);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		tokenize_byte(b, eoi);
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= eoi;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		bytes_sent++;
	endtask

	// random byte that is none of quote, comma, cr, lf
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		if (b == CH_QUOTE || b == CH_COMMA || b == CH_CR || b == CH_LF)
			b = b ^ 8'h40;
		return b;
	endfunction

	// checker and receiver side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_tokens.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected token: kind %0d data %02h last %0b",
						m_tuser, m_tdata, m_tlast);
			end else begin
				want = expected_tokens.pop_front();
				if (m_tuser !== want.kind || m_tdata !== want.data
						|| m_tlast !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("token mismatch: exp %0d/%02h/%0b got %0d/%02h/%0b",
							want.kind, want.data, want.last, m_tuser, m_tdata, m_tlast);
				end
			end
		end
		m_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);
	end

	// content extremes, quoted field, doubled quote, byte after closing quote, cr lf
	task automatic test_quoting();
		send_text_byte(8'h00, 1'b0);
		send_text_byte(CH_COMMA, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(8'hff, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(8'h78, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(CH_LF, 1'b0);
	endtask

	// blank lines, empty quoted field, quote inside a started field, lone cr
	task automatic test_row_endings();
		send_text_byte(CH_LF, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(8'h62, 1'b0);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(CH_CR, 1'b0);
		send_text_byte(CH_COMMA, 1'b0);
	endtask

	// final quote, unterminated quoted field, final cr
	task automatic test_end_of_input();
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(8'h7a, 1'b0);
		send_text_byte(CH_QUOTE, 1'b1);
		send_text_byte(CH_QUOTE, 1'b0);
		send_text_byte(8'h79, 1'b1);
		send_text_byte(8'h61, 1'b0);
		send_text_byte(CH_CR, 1'b1);
	endtask

	task automatic test_random_text(input int n_bytes);
		int target;
		int pick;
		int len;
		target = bytes_sent + n_bytes;
		while (bytes_sent < target) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				send_text_byte(8'($urandom_range(255)), $urandom_range(15) == 0);
			end else if (pick < 40) begin
				len = $urandom_range(4, 1);
				repeat (len)
					send_text_byte(plain_byte(), 1'b0);
			end else if (pick < 55) begin
				send_text_byte(CH_COMMA, 1'b0);
			end else if (pick < 72) begin
				send_text_byte(CH_QUOTE, 1'b0);
				len = $urandom_range(4);
				repeat (len) begin
					case ($urandom_range(5))
						0: begin
							send_text_byte(CH_QUOTE, 1'b0);
							send_text_byte(CH_QUOTE, 1'b0);
						end
						1: send_text_byte(($urandom_range(1) != 0) ? CH_COMMA : CH_LF, 1'b0);
						default: send_text_byte(plain_byte(), 1'b0);
					endcase
				end
				send_text_byte(CH_QUOTE, 1'b0);
			end else if (pick < 90) begin
				case ($urandom_range(2))
					0: begin
						send_text_byte(CH_CR, 1'b0);
						send_text_byte(CH_LF, 1'b0);
					end
					1: send_text_byte(CH_CR, 1'b0);
					default: send_text_byte(CH_LF, 1'b0);
				endcase
			end else begin
				send_text_byte(8'($urandom_range(255)), 1'b1);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 26;
		recv_idle_pct = 59;
		test_quoting();
		test_row_endings();
		test_end_of_input();
		test_random_text(80);

		send_idle_pct = 59;
		recv_idle_pct = 26;
		test_random_text(80);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_text(75);

		s_tvalid <= 1'b0;
		while (expected_tokens.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		if (mismatch_count == 0 && expected_tokens.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#3000000;
		$display("status: fail");
		$finish;
	end

endmodule
